/* design/fmlg_pkg.sv */
// ----------------------------------------------------------------------------
// fmlg_pkg
// Shared codes, widths and types of the first matching line grep block.
// ----------------------------------------------------------------------------
package fmlg_pkg;

  // Request actions.
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_EOF  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_TAKEN   = 2'd0;
  localparam logic [1:0] ST_MATCH   = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAP = 3'd5;

  localparam int CFG_DATA_W    = 64;
  localparam int KEY_WORDS     = 4;
  localparam int KEY_REG_BYTES = 32;
  localparam int KEY_LEN_W     = 6;
  localparam int OUT_CAP_W     = 13;
  localparam logic [OUT_CAP_W-1:0] OUT_CAP_RESET = 13'd512;

  localparam logic [7:0] NEWLINE = 8'h0A;

  // Field widths of the channels.
  localparam int ACTION_W = 2;
  localparam int RIDX_W   = 9;
  localparam int STATUS_W = 2;
  localparam int CLEN_W   = 9;

  // Control from the top level to the keyword window.
  typedef struct packed {
    logic       shift;
    logic [7:0] din;
  } win_ctl_t;

endpackage

/* design/fmlg_in_if.sv */
// ----------------------------------------------------------------------------
// fmlg_in_if
// Request channel: action, file byte and read index with valid/ready.
// ----------------------------------------------------------------------------
interface fmlg_in_if;
  import fmlg_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [7:0]          data_byte;
  logic [RIDX_W-1:0]   read_index;

  modport source (output valid, output action, output data_byte, output read_index,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input read_index,
                  output ready);
endinterface

/* design/fmlg_out_if.sv */
// ----------------------------------------------------------------------------
// fmlg_out_if
// Result channel: status, copy length and read byte with valid/ready.
// ----------------------------------------------------------------------------
interface fmlg_out_if;
  import fmlg_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CLEN_W-1:0]   copy_length;
  logic [7:0]          read_byte;

  modport source (output valid, output status, output copy_length, output read_byte,
                  input ready);
  modport sink   (input valid, input status, input copy_length, input read_byte,
                  output ready);
endinterface

/* design/first_matching_line_grep.sv */
// ----------------------------------------------------------------------------
// first_matching_line_grep
// Streams file bytes into a line memory and keeps the first line that holds
// the keyword; the kept line can be read back byte by byte.
// ----------------------------------------------------------------------------
// Every request produces one result in the output register in the cycle
// after its acceptance, so that a request can be accepted on
// every clock while results are taken. A file byte is written into the line
// memory and shifted into the keyword window in the same cycle, where all
// keyword positions are compared at once; a read request uses the memory's
// single registered read port. The line memory holds LINE_MAX bytes and is
// not cleared by reset: only positions of the kept line should be read.
// Configuration must be written through the cfg_ port while no request is in
// flight (the block does not enforce this); out_cap resets to 512, the keyword to empty.
module first_matching_line_grep #(
  parameter int LINE_MAX = 512,
  parameter int KEY_MAX  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [fmlg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fmlg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  fmlg_in_if.sink                               in_req,
  fmlg_out_if.source                            out_res
);
  import fmlg_pkg::*;

  localparam int AW   = $clog2(LINE_MAX);
  localparam int NW   = $clog2(KEY_MAX + 1);
  localparam int IW   = ((AW > RIDX_W) ? AW : RIDX_W) + 1;
  localparam int CW   = (AW > OUT_CAP_W) ? AW : OUT_CAP_W;
  localparam int MW   = (AW > NW) ? AW : NW;
  localparam int KLW  = (KEY_LEN_W > NW) ? KEY_LEN_W : NW;

  // Configuration registers.
  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [CFG_DATA_W-1:0] key_w_r [KEY_WORDS];
  logic [OUT_CAP_W-1:0]  out_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      out_cap_r <= OUT_CAP_RESET;
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_w_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LEN: key_len_r  <= cfg_wdata[KEY_LEN_W-1:0];
        REG_KEY_W0:  key_w_r[0] <= cfg_wdata;
        REG_KEY_W1:  key_w_r[1] <= cfg_wdata;
        REG_KEY_W2:  key_w_r[2] <= cfg_wdata;
        REG_KEY_W3:  key_w_r[3] <= cfg_wdata;
        REG_OUT_CAP: out_cap_r  <= cfg_wdata[OUT_CAP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [KEY_REG_BYTES*8-1:0] key_flat;
  assign key_flat = {key_w_r[3], key_w_r[2], key_w_r[1], key_w_r[0]};

  logic [NW-1:0] key_n;
  assign key_n = (KLW'(key_len_r) > KLW'(KEY_MAX)) ? NW'(KEY_MAX) : NW'(key_len_r);

  logic [OUT_CAP_W-1:0] cap;
  assign cap = ((out_cap_r < OUT_CAP_W'(2)) ? OUT_CAP_W'(2) : out_cap_r) - OUT_CAP_W'(1);

  // Match state.
  logic [AW-1:0]     line_len_r, line_len_nxt;
  logic              hit_r, hit_nxt;
  logic              found_r, found_nxt;
  logic [CLEN_W-1:0] match_len_r, match_len_nxt;

  // Output stage.
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CLEN_W-1:0]   clen_r, clen_nxt;
  logic                rd_sel_r, rd_sel_nxt;
  logic [7:0]          rd_data_r;

  logic accept;
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;

  win_ctl_t win_ctl;
  logic     win_eq;

  fmlg_window #(.KEY_MAX(KEY_MAX)) u_window (
    .clk      (clk),
    .ctl      (win_ctl),
    .key_flat (key_flat),
    .key_n    (key_n),
    .eq       (win_eq)
  );

  logic              line_match;
  logic [CLEN_W-1:0] capped_len;
  logic              line_end;
  logic [AW-1:0]     new_len;
  logic [IW-1:0]     rd_idx_ext;
  logic              rd_in_range;
  logic              rd_en;

  assign line_match  = (key_n == '0) || hit_r;
  assign capped_len  = (CW'(line_len_r) < CW'(cap)) ? CLEN_W'(line_len_r) : CLEN_W'(cap);
  assign line_end    = (in_req.data_byte == NEWLINE) || (line_len_r >= AW'(LINE_MAX - 1));
  assign new_len     = line_len_r + AW'(1);
  assign rd_idx_ext  = IW'(in_req.read_index);
  assign rd_in_range = rd_idx_ext < IW'(LINE_MAX);
  assign rd_en       = accept && (in_req.action == ACT_READ) && rd_in_range;

  always_comb begin
    line_len_nxt  = line_len_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    match_len_nxt = match_len_r;
    status_nxt    = ST_TAKEN;
    clen_nxt      = '0;
    rd_sel_nxt    = 1'b0;
    win_ctl.shift = 1'b0;
    win_ctl.din   = in_req.data_byte;
    if (accept) begin
      case (in_req.action)
        ACT_BYTE: begin
          if (!found_r) begin
            if (line_end) begin
              if (line_match) begin
                found_nxt     = 1'b1;
                match_len_nxt = capped_len;
                status_nxt    = ST_MATCH;
                clen_nxt      = capped_len;
              end else begin
                line_len_nxt = '0;
                hit_nxt      = 1'b0;
              end
            end else begin
              win_ctl.shift = 1'b1;
              line_len_nxt  = new_len;
              if (key_n != '0 && MW'(new_len) >= MW'(key_n) && win_eq) begin
                hit_nxt = 1'b1;
              end
            end
          end
        end
        ACT_EOF: begin
          if (found_r) begin
            status_nxt = ST_MATCH;
            clen_nxt   = match_len_r;
          end else if (line_len_r != '0 && line_match) begin
            found_nxt     = 1'b1;
            match_len_nxt = capped_len;
            status_nxt    = ST_MATCH;
            clen_nxt      = capped_len;
          end else begin
            status_nxt = ST_NOMATCH;
          end
        end
        ACT_READ: begin
          status_nxt = ST_READ;
          rd_sel_nxt = rd_in_range;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      hit_r       <= 1'b0;
      found_r     <= 1'b0;
      match_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      line_len_r  <= line_len_nxt;
      hit_r       <= hit_nxt;
      found_r     <= found_nxt;
      match_len_r <= match_len_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      clen_r   <= clen_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  // Line memory: one write port for stored bytes, one registered read port.
  logic [7:0] line_mem [LINE_MAX];

  always_ff @(posedge clk) begin
    if (win_ctl.shift) begin
      line_mem[line_len_r] <= in_req.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_idx_ext[AW-1:0]];
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = status_r;
  assign out_res.copy_length = clen_r;
  assign out_res.read_byte   = rd_sel_r ? rd_data_r : 8'h00;

  // Once a line is kept it stays kept until reset.
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |=> found_r)
    else $error("kept line was dropped");

  // The kept line is frozen: no further bytes change its length.
  a_found_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |=> $stable(line_len_r))
    else $error("line length changed after a match");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= AW'(LINE_MAX - 1))
    else $error("line length beyond buffer");

  a_clen_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_MATCH) |-> (clen_r == '0))
    else $error("copy length reported without a match");

  a_rbyte_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_READ) |-> (out_res.read_byte == 8'h00))
    else $error("read byte reported on a non-read result");

endmodule

/* design/fmlg_window.sv */
// ----------------------------------------------------------------------------
// fmlg_window
// Shift window of the newest stored bytes, compared against the keyword.
// ----------------------------------------------------------------------------
module fmlg_window #(
  parameter int KEY_MAX = 32,
  localparam int NW = $clog2(KEY_MAX + 1)
) (
  input  logic                                      clk,
  input  fmlg_pkg::win_ctl_t                        ctl,
  input  logic [fmlg_pkg::KEY_REG_BYTES*8-1:0]      key_flat,
  input  logic [NW-1:0]                             key_n,
  output logic                                      eq
);
  import fmlg_pkg::*;

  logic [7:0] win_r [KEY_MAX];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r[0] <= ctl.din;
      for (int k = 1; k < KEY_MAX; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  // Position k of the shifted window holds the byte k places back; it must
  // equal keyword byte n-1-k for every k below n.
  always_comb begin
    int         idx;
    logic [7:0] wb;
    logic [7:0] kb;
    logic       miss;
    miss = 1'b0;
    for (int k = 0; k < KEY_MAX; k++) begin
      idx = int'(key_n) - 1 - k;
      wb  = (k == 0) ? ctl.din : win_r[(k == 0) ? 0 : k - 1];
      kb  = 8'h00;
      if (idx >= 0 && idx < KEY_REG_BYTES) begin
        kb = key_flat[idx*8 +: 8];
      end
      if (k < int'(key_n) && wb != kb) begin
        miss = 1'b1;
      end
    end
    eq = !miss;
  end

endmodule

/* tb/sv/tb_first_matching_line_grep.sv */
// ----------------------------------------------------------------------------
// tb_first_matching_line_grep
// Self-checking testbench for the first matching line grep block. A directed
// opening is followed by random search phases with a new keyword and output
// cap each. File bytes are built into lines that carry near misses of the
// keyword, keyword halves split across lines, empty lines and full-length
// lines. A final phase plants the keyword so that a line is kept, then
// checks the ignored bytes, repeated end of file and read-back. A scoreboard
// predicts every result and compares it field by field, with random idle
// gaps on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_first_matching_line_grep;
  timeunit 1ns;
  timeprecision 1ps;

  import fmlg_pkg::*;

  localparam int LINE_MAX    = 512;
  localparam int ITEMS       = 1900;
  localparam int LONG_HOLD   = 200;
  localparam int STALL_LIMIT = 2000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Opening requests: action on top, file byte or read index below.
  localparam logic [9:0] OPENING_SEQ [0:21] = '{
    {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, 8'h80}, {ACT_BYTE, 8'h7F},
    {ACT_BYTE, 8'h67}, {ACT_BYTE, 8'h72}, {ACT_BYTE, 8'h65}, {ACT_BYTE, NEWLINE},
    {ACT_BYTE, NEWLINE}, {ACT_BYTE, 8'h67}, {ACT_BYTE, 8'h72}, {ACT_EOF, 8'h00},
    {ACT_BYTE, 8'h65}, {ACT_BYTE, 8'h78}, {ACT_BYTE, NEWLINE}, {ACT_BYTE, 8'h67},
    {ACT_BYTE, 8'h72}, {ACT_BYTE, NEWLINE}, {ACT_BYTE, 8'h65}, {ACT_BYTE, 8'h70},
    {ACT_BYTE, NEWLINE}, {ACT_READ, 8'd6}
  };

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLEN_W-1:0]   copy_length;
    logic [7:0]          read_byte;
  } grep_result_t;

  class line_grep_tracker;
    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [7:0]           key_bytes [KEY_REG_BYTES];
    logic [OUT_CAP_W-1:0] out_cap_reg;
    bit [7:0]             line_mem [LINE_MAX];
    logic [7:0]           window [KEY_REG_BYTES];
    int                   line_len;
    int                   high_water;
    bit                   line_hit;
    bit                   found;
    logic [CLEN_W-1:0]    kept_len;
    grep_result_t         pending [$];
    int                   errors;
    int                   status_seen [4];

    function new();
      key_len_reg = '0;
      out_cap_reg = OUT_CAP_RESET;
      foreach (key_bytes[i]) key_bytes[i] = 8'h00;
      foreach (window[i]) window[i] = 8'h00;
      line_len = 0;
      high_water = 0;
      line_hit = 1'b0;
      found = 1'b0;
      kept_len = '0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      int w;
      w = int'(idx) - int'(REG_KEY_W0);
      case (idx)
        REG_KEY_LEN: key_len_reg = val[KEY_LEN_W-1:0];
        REG_KEY_W0, REG_KEY_W1, REG_KEY_W2, REG_KEY_W3: begin
          for (int b = 0; b < 8; b++) key_bytes[w * 8 + b] = val[8 * b +: 8];
        end
        REG_OUT_CAP: out_cap_reg = val[OUT_CAP_W-1:0];
        default: ;
      endcase
    endfunction

    function int key_used();
      return (key_len_reg > KEY_REG_BYTES) ? KEY_REG_BYTES : int'(key_len_reg);
    endfunction

    function logic [CLEN_W-1:0] capped_length();
      int cap;
      cap = ((out_cap_reg < 2) ? 2 : int'(out_cap_reg)) - 1;
      return CLEN_W'((line_len < cap) ? line_len : cap);
    endfunction

    // Stores a byte and compares the newest key_used() bytes with the keyword.
    function void store_byte(logic [7:0] c);
      int  n;
      bit  same;
      n = key_used();
      same = 1'b1;
      line_mem[line_len] = c;
      line_len++;
      if (line_len > high_water) high_water = line_len;
      for (int k = KEY_REG_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = c;
      if (n == 0 || line_len < n) return;
      for (int k = 0; k < n; k++)
        if (window[k] != key_bytes[n - 1 - k]) same = 1'b0;
      if (same) line_hit = 1'b1;
    endfunction

    function void keep_line(ref grep_result_t r);
      found = 1'b1;
      kept_len = capped_length();
      r.status = ST_MATCH;
      r.copy_length = kept_len;
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [7:0] d,
                               logic [RIDX_W-1:0] ridx);
      grep_result_t r;
      r = '{status: ST_TAKEN, copy_length: '0, read_byte: 8'h00};
      case (act)
        ACT_BYTE: begin
          if (!found) begin
            if (d == NEWLINE || line_len >= LINE_MAX - 1) begin
              if (key_used() == 0 || line_hit) begin
                keep_line(r);
              end else begin
                line_len = 0;
                line_hit = 1'b0;
              end
            end else begin
              store_byte(d);
            end
          end
        end
        ACT_EOF: begin
          if (found) begin
            r.status = ST_MATCH;
            r.copy_length = kept_len;
          end else if (line_len > 0 && (key_used() == 0 || line_hit)) begin
            keep_line(r);
          end else begin
            r.status = ST_NOMATCH;
          end
        end
        ACT_READ: begin
          r.status = ST_READ;
          if (ridx < LINE_MAX) r.read_byte = line_mem[ridx];
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [CLEN_W-1:0] cl,
                               logic [7:0] rb);
      grep_result_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: status=%0d copy_length=%0d read_byte=%0h",
               st, cl, rb);
        errors++;
        return;
      end
      e = pending.pop_front();
      status_seen[e.status]++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (cl !== e.copy_length) begin
        $error("copy_length: expected %0d, got %0d", e.copy_length, cl);
        errors++;
      end
      if (rb !== e.read_byte) begin
        $error("read_byte: expected %0h, got %0h", e.read_byte, rb);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fmlg_in_if  req_if ();
  fmlg_out_if res_if ();

  first_matching_line_grep #(
    .LINE_MAX (LINE_MAX),
    .KEY_MAX  (KEY_REG_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_if),
    .out_res   (res_if)
  );

  line_grep_tracker tracker = new();

  int         requests_sent = 0;
  int         settings_count = 0;
  int         quiet_cycles = 0;
  bit         src_quiet = 1'b0;
  bit         snk_quiet = 1'b0;
  bit         hold_results_req = 1'b0;
  int         key_n = 0;
  logic [7:0] key_plan [KEY_REG_BYTES];
  logic [7:0] line_buf [LINE_MAX];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NEWLINE);
    return b;
  endfunction

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results_req) begin
        res_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results_req = 1'b0;
      end else begin
        stall = snk_quiet ? 0 : pick_gap();
        res_if.ready = (stall == 0);
        if (stall > 0) repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_result(res_if.status, res_if.copy_length, res_if.read_byte);
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [7:0] d,
                              input logic [RIDX_W-1:0] ridx);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid = 1'b1;
    req_if.action = act;
    req_if.data_byte = d;
    req_if.read_index = ridx;
    do @(posedge clk); while (!req_if.ready);
    tracker.note_request(act, d, ridx);
    requests_sent++;
  endtask

  // Only entries below the high-water mark have ever been written.
  task automatic send_read();
    if (tracker.high_water > 0)
      send_request(ACT_READ, 8'($urandom),
                   RIDX_W'($urandom_range(0, tracker.high_water - 1)));
  endtask

  task automatic maybe_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) send_read();
    else if (r < 7) send_request(ACT_EOF, 8'($urandom), RIDX_W'($urandom));
    else if (r < 8) send_request(ACT_UNUSED, 8'($urandom), RIDX_W'($urandom));
  endtask

  // Sends one line of len bytes with key_plan[kfrom:kto-1] placed at pos,
  // one keyword byte changed when alter is set, then the line end or EOF.
  task automatic send_line(input int len, input int pos, input int kfrom, input int kto,
                           input bit alter, input bit eof_end);
    int         j;
    logic [7:0] b;
    for (int i = 0; i < len; i++) line_buf[i] = rand_text_byte();
    for (int i = kfrom; i < kto; i++) line_buf[pos + i - kfrom] = key_plan[i];
    if (alter && kto > kfrom) begin
      j = pos + $urandom_range(0, kto - kfrom - 1);
      do b = rand_text_byte(); while (b == line_buf[j]);
      line_buf[j] = b;
    end
    for (int i = 0; i < len; i++) begin
      maybe_noise();
      send_request(ACT_BYTE, line_buf[i], RIDX_W'($urandom));
    end
    if (eof_end)
      send_request(ACT_EOF, 8'($urandom), RIDX_W'($urandom));
    else if (len >= LINE_MAX - 1)
      send_request(ACT_BYTE, $urandom_range(0, 1) ? NEWLINE : rand_text_byte(),
                   RIDX_W'($urandom));
    else
      send_request(ACT_BYTE, NEWLINE, RIDX_W'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // Writes every register; unused upper data bits carry random values.
  task automatic apply_settings(input logic [KEY_LEN_W-1:0] len_code,
                                input logic [OUT_CAP_W-1:0] cap);
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};
    word[KEY_LEN_W-1:0] = len_code;
    write_cfg(REG_KEY_LEN, word);
    for (int w = 0; w < KEY_WORDS; w++) begin
      for (int b = 0; b < 8; b++) word[8 * b +: 8] = key_plan[8 * w + b];
      write_cfg(CFG_IDX_W'(int'(REG_KEY_W0) + w), word);
    end
    word = {$urandom, $urandom};
    word[OUT_CAP_W-1:0] = cap;
    write_cfg(REG_OUT_CAP, word);
    @(negedge clk);
    cfg_we = 1'b0;
    key_n = (len_code > KEY_REG_BYTES) ? KEY_REG_BYTES : int'(len_code);
    settings_count++;
  endtask

  task automatic new_keyword();
    foreach (key_plan[i]) key_plan[i] = rand_text_byte();
  endtask

  // Lines that must not match: near misses, prefixes at a line end and a
  // keyword split across two lines, which the line reset must not join.
  task automatic run_search_phase(input int lines);
    int len, kind, k;
    for (int l = 0; l < lines; l++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) len = 0;
      else if (kind < 85) len = $urandom_range(1, 40);
      else if (kind < 97) len = $urandom_range(41, 200);
      else len = $urandom_range(201, LINE_MAX - 2);
      k = $urandom_range(1, key_n - 1);
      case ($urandom_range(0, 3))
        1: begin
          if (len < key_n) len = key_n;
          send_line(len, $urandom_range(0, len - key_n), 0, key_n, 1'b1, 1'b0);
        end
        2: begin
          if (len < k) len = k;
          send_line(len, len - k, 0, k, 1'b0, 1'b0);
        end
        3: begin
          if (len < k) len = k;
          send_line(len, len - k, 0, k, 1'b0, 1'b0);
          len = $urandom_range(key_n - k, key_n - k + 20);
          send_line(len, 0, k, key_n, 1'b0, 1'b0);
        end
        default: send_line(len, 0, 0, 0, 1'b0, 1'b0);
      endcase
    end
  endtask

  initial begin
    int                   phase, lines, mode, final_len, reserve, pos;
    bit                   eof_end;
    logic [KEY_LEN_W-1:0] len_code;
    logic [OUT_CAP_W-1:0] cap;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_LEN;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.action = ACT_BYTE;
    req_if.data_byte = 8'h00;
    req_if.read_index = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Empty keyword at reset: end of file on an empty line finds nothing.
    send_request(ACT_EOF, 8'hFF, 9'h1FF);
    send_request(ACT_UNUSED, 8'hFF, 9'h1FF);
    drain_results();

    // Keyword "grep"; the opening lines only come close to it.
    new_keyword();
    key_plan[0] = 8'h67;
    key_plan[1] = 8'h72;
    key_plan[2] = 8'h65;
    key_plan[3] = 8'h70;
    apply_settings(6'd4, 13'd4096);
    foreach (OPENING_SEQ[i]) begin
      if (OPENING_SEQ[i][9:8] == ACT_READ)
        send_request(ACT_READ, 8'($urandom), {1'b0, OPENING_SEQ[i][7:0]});
      else
        send_request(OPENING_SEQ[i][9:8], OPENING_SEQ[i][7:0], RIDX_W'($urandom));
    end
    drain_results();

    // Plan the final phase first so that its length is kept in reserve.
    mode = $urandom_range(0, 3);
    case (mode)
      0: len_code = 6'd0;
      1: len_code = KEY_LEN_W'($urandom_range(1, 3));
      2: len_code = KEY_LEN_W'($urandom_range(4, KEY_REG_BYTES));
      default: len_code = KEY_LEN_W'($urandom_range(KEY_REG_BYTES + 1, 63));
    endcase
    final_len = ($urandom_range(0, 3) == 0) ? LINE_MAX - 1 :
                $urandom_range(KEY_REG_BYTES, KEY_REG_BYTES + 40);
    eof_end = (final_len < LINE_MAX - 1) && ($urandom_range(0, 2) == 0);
    reserve = final_len + 120;

    // The second phase carries the long hold-off, so it always runs.
    phase = 0;
    while (phase < 2 || requests_sent < ITEMS - reserve) begin
      phase++;
      new_keyword();
      case (phase)
        1: apply_settings(6'd4, 13'd4096);
        2: apply_settings(6'd32, 13'd2);
        3: apply_settings(6'd63, 13'd0);
        4: apply_settings(KEY_LEN_W'($urandom_range(5, 31)), 13'd1);
        default: apply_settings(KEY_LEN_W'($urandom_range(4, 63)),
                                OUT_CAP_W'($urandom_range(0, 4096)));
      endcase
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      lines = $urandom_range(4, 12);
      if (phase == 1) begin
        send_line(LINE_MAX - 1, 0, 0, 0, 1'b0, 1'b0);
        repeat (10) send_read();
      end
      if (phase == 2) begin
        // Results are held back while requests keep coming.
        src_quiet = 1'b1;
        hold_results_req = 1'b1;
      end
      if (phase == 3) begin
        run_search_phase(lines / 2);
        drain_results();
      end
      run_search_phase(lines);
      drain_results();
    end

    // Final phase: a line that holds the keyword (or any line for an empty
    // keyword) is kept; later bytes are ignored and reads return it.
    new_keyword();
    case ($urandom_range(0, 5))
      0: cap = 13'd0;
      1: cap = 13'd1;
      2: cap = 13'd2;
      3: cap = 13'd4096;
      4: cap = OUT_CAP_W'($urandom_range(2, 40));
      default: cap = OUT_CAP_W'($urandom_range(2, 4096));
    endcase
    apply_settings(len_code, cap);
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
    if (mode == 0) begin
      if ($urandom_range(0, 3) == 0) final_len = 0;
    end else begin
      repeat (2) send_line($urandom_range(0, 20), 0, 0, 0, 1'b0, 1'b0);
    end
    pos = $urandom_range(0, final_len - key_n);
    send_line(final_len, pos, 0, key_n, 1'b0, eof_end);
    repeat (20) begin
      case ($urandom_range(0, 2))
        0: send_request(ACT_BYTE, 8'($urandom), RIDX_W'($urandom));
        1: send_request(ACT_EOF, 8'($urandom), RIDX_W'($urandom));
        default: send_read();
      endcase
    end
    repeat (40) begin
      if (tracker.found && tracker.line_len > 0)
        send_request(ACT_READ, 8'($urandom),
                     RIDX_W'($urandom_range(0, tracker.line_len - 1)));
      else
        send_read();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d results never arrived", tracker.pending.size());
      tracker.errors++;
    end
    $display("Sent %0d requests under %0d register settings; line kept: %0d, length %0d.",
             requests_sent, settings_count, tracker.found, tracker.line_len);
    $display("Results checked: %0d taken, %0d match, %0d no match, %0d read back.",
             tracker.status_seen[ST_TAKEN], tracker.status_seen[ST_MATCH],
             tracker.status_seen[ST_NOMATCH], tracker.status_seen[ST_READ]);
    if (tracker.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* first_matching_line_grep.f */
design/fmlg_pkg.sv
design/fmlg_in_if.sv
design/fmlg_out_if.sv
design/fmlg_window.sv
design/first_matching_line_grep.sv
tb/sv/tb_first_matching_line_grep.sv
